/* hw/rtl/sdx_pkg.sv */
// ----------------------------------------------------------------------------
// sdx_pkg
// Types, letter code table and helpers shared by the phonetic code encoder.
// ----------------------------------------------------------------------------
package sdx_pkg;

  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 3;

  localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0]  CHAR_Z     = 8'h5a;
  localparam logic [DIGIT_W-1:0] CODE_SKIP  = 3'd0;

  typedef struct packed {
    logic [CHAR_W-1:0] letter;
    logic              is_first;
    logic              is_last;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  lead_letter;
    logic [DIGIT_W-1:0] digit_one;
    logic [DIGIT_W-1:0] digit_two;
    logic [DIGIT_W-1:0] digit_three;
  } code_t;

  localparam logic [DIGIT_W-1:0] LETTER_CODE [26] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
    3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
  };

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_A) && (c <= CHAR_Z);
  endfunction

  function automatic logic [DIGIT_W-1:0] letter_code(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] off;
    off = c - CHAR_A;
    if (is_upper(c)) begin
      return LETTER_CODE[off[4:0]];
    end
    return CODE_SKIP;
  endfunction

endpackage

/* hw/rtl/soundex_encoder_core.sv */
// ----------------------------------------------------------------------------
// soundex_encoder_core
// Phonetic code encoder: one character per transfer, code on the end mark.
// ----------------------------------------------------------------------------
// Output: an end character passes through the input register, then its code is loaded into the result register.
// Throughput: one character per cycle; the state update is one table lookup
//   and compare between the input register and the result register. An end
//   character waits in the input register while the result register is stalled.
// Reset: synchronous; clears both valid flags, the lead letter, prior code and
//   digit count.
module soundex_encoder_core #(
  parameter int CODE_LENGTH = 3
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  sdx_pkg::item_t item,
  output logic           code_valid,
  input  logic           code_stall,
  output sdx_pkg::code_t code
);
  import sdx_pkg::*;

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);

  logic               held_valid;
  item_t              held;
  logic [CHAR_W-1:0]  lead;
  logic [DIGIT_W-1:0] prior;
  logic [CNT_W-1:0]   count;
  logic [DIGIT_W-1:0] digits [CODE_LENGTH];

  logic [CHAR_W-1:0]  lead_next;
  logic [DIGIT_W-1:0] prior_next;
  logic [CNT_W-1:0]   count_next;
  logic [DIGIT_W-1:0] digits_next [CODE_LENGTH];
  code_t              result;

  logic out_free;
  logic step;

  sdx_step #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_step (
    .item       (held),
    .lead       (lead),
    .prior      (prior),
    .count      (count),
    .digits     (digits),
    .lead_next  (lead_next),
    .prior_next (prior_next),
    .count_next (count_next),
    .digits_next(digits_next),
    .result     (result)
  );

  assign out_free   = !code_valid || !code_stall;
  assign step       = held_valid && (!held.is_last || out_free);
  assign item_stall = held_valid && !step;

  // hold the next character
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  // advance the name state
  always_ff @(posedge clk) begin
    if (rst) begin
      lead  <= '0;
      prior <= '0;
      count <= '0;
    end else if (step) begin
      lead  <= lead_next;
      prior <= prior_next;
      count <= count_next;
    end
    if (step) begin
      digits <= digits_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (out_free) begin
      code_valid <= step && held.is_last;
    end
    if (step && held.is_last) begin
      code <= result;
    end
  end

endmodule

/* hw/rtl/sdx_step.sv */
// ----------------------------------------------------------------------------
// sdx_step
// Per-character update of the name state and the code seen after it.
// ----------------------------------------------------------------------------
module sdx_step #(
  parameter int CODE_LENGTH = 3,
  localparam int CNT_W = $clog2(CODE_LENGTH + 1)
) (
  input  sdx_pkg::item_t                      item,
  input  logic [sdx_pkg::CHAR_W-1:0]          lead,
  input  logic [sdx_pkg::DIGIT_W-1:0]         prior,
  input  logic [CNT_W-1:0]                    count,
  input  logic [sdx_pkg::DIGIT_W-1:0]         digits [CODE_LENGTH],
  output logic [sdx_pkg::CHAR_W-1:0]          lead_next,
  output logic [sdx_pkg::DIGIT_W-1:0]         prior_next,
  output logic [CNT_W-1:0]                    count_next,
  output logic [sdx_pkg::DIGIT_W-1:0]         digits_next [CODE_LENGTH],
  output sdx_pkg::code_t                      result
);
  import sdx_pkg::*;

  logic [DIGIT_W-1:0] code;
  logic               upper;
  logic [DIGIT_W-1:0] slot [3];

  assign code  = letter_code(item.letter);
  assign upper = is_upper(item.letter);

  always_comb begin
    lead_next   = lead;
    prior_next  = prior;
    count_next  = count;
    digits_next = digits;
    if (item.is_first) begin
      lead_next  = item.letter;
      prior_next = code;
      count_next = '0;
    end else if (upper && (count < CNT_W'(CODE_LENGTH))) begin
      if (code == CODE_SKIP) begin
        prior_next = CODE_SKIP;
      end else begin
        if (code != prior) begin
          for (int i = 0; i < CODE_LENGTH; i++) begin
            if (count == CNT_W'(i)) begin
              digits_next[i] = code;
            end
          end
          count_next = count + CNT_W'(1);
        end
        prior_next = code;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_slot
    if (k < CODE_LENGTH) begin : g_held
      assign slot[k] = (count_next > CNT_W'(k)) ? digits_next[k] : CODE_SKIP;
    end else begin : g_pad
      assign slot[k] = CODE_SKIP;
    end
  end

  assign result.lead_letter = lead_next;
  assign result.digit_one   = slot[0];
  assign result.digit_two   = slot[1];
  assign result.digit_three = slot[2];

endmodule
